@@ rtl/bta_pkg.sv @@
// package: sizes, operation codes and status codes of the block table allocator
`default_nettype none

package bta_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned BLOCK_BYTES   = 32;

  localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENTRY_W   = IDX_W + 1;
  localparam int unsigned BLK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned OFS_W    = 15;
  localparam int unsigned COUNT_W  = 16;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FN_ALLOC  = 2'd0;
  localparam func_t FN_FREE   = 2'd1;
  localparam func_t FN_SIZE   = 2'd2;
  localparam func_t FN_FBYTES = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NOFIT = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

endpackage

`default_nettype wire

@@ rtl/block_table_allocator.sv @@
// top level: first-fit block allocator over a run-length block table
//
// usage: a request is taken when start is high and busy is low. in_func
// selects alloc, free, size-of or free-bytes; in_request_bytes is used by
// alloc, in_byte_offset by free and size-of. exactly one result follows each
// request, shown for one cycle on out_status, out_alloc_offset and
// out_byte_count with out_valid high; the receiver cannot hold it off.
// free-bytes, zero or oversize alloc and out-of-range offsets give their
// result in the cycle after the request and busy stays low. size-of reads
// the entry in the lookup state, then gives its result. free reads the head
// entry in the lookup state, then clears any run there in the wipe state (up
// to 1024 entries). alloc scans the table, one entry or one used run per
// cycle, then writes the new run one entry per cycle, one table read and
// one table write per cycle setting the pace.
// busy is high for the whole operation; requests are taken one at a time.
// reset: synchronous, rst_n low. after reset a clearing pass writes zero to
// all 1024 table entries, one per cycle, with busy high throughout.
`default_nettype none

module block_table_allocator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [bta_pkg::FUNC_W-1:0]          in_func,
  input  wire  [bta_pkg::BYTES_W-1:0]         in_request_bytes,
  input  wire  [bta_pkg::BYTES_W-1:0]         in_byte_offset,
  output logic                                out_valid,
  output logic [bta_pkg::STATUS_W-1:0]        out_status,
  output logic [bta_pkg::OFS_W-1:0]           out_alloc_offset,
  output logic [bta_pkg::COUNT_W-1:0]         out_byte_count
);
  import bta_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_LOOKUP,
    S_WIPE
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     start_r, start_nxt;
  logic [IDX_W-1:0]     last_r, last_nxt;
  logic [ENTRY_W-1:0]   need_r, need_nxt;
  logic [ENTRY_W-1:0]   run_r, run_nxt;
  logic [ENTRY_W-1:0]   left_r, left_nxt;
  logic [ENTRY_W-1:0]   free_r, free_nxt;
  logic                 is_free_r, is_free_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [OFS_W-1:0]     out_ofs_r, out_ofs_nxt;
  logic [COUNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  // table memory
  logic [ENTRY_W-1:0]   mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]     mem_raddr;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // request decode
  logic [BYTES_W:0]     need_w;
  logic [BYTES_W-1:0]   blk_w;
  logic [31:0]          fbytes_w;
  logic [31:0]          size_w;
  logic [31:0]          aofs_w;

  // scan adders and free-count adder
  logic [ENTRY_W-1:0]   step_w;
  logic [ENTRY_W:0]     sum_w;
  logic [ENTRY_W-1:0]   run_inc_w;
  logic [ENTRY_W:0]     fsum_w;

  assign need_w    = (BYTES_W+1)'(in_request_bytes >> BLK_SHIFT)
                   + (BYTES_W+1)'(|(in_request_bytes & BYTES_W'(BLOCK_BYTES - 1)));
  assign blk_w     = in_byte_offset >> BLK_SHIFT;
  assign fbytes_w  = 32'(free_r) << BLK_SHIFT;
  assign size_w    = 32'(rd_data_r) << BLK_SHIFT;
  assign aofs_w    = 32'(start_r) << BLK_SHIFT;
  assign step_w    = (rd_data_r == '0) ? ENTRY_W'(1) : rd_data_r;
  assign sum_w     = (ENTRY_W+1)'(idx_r) + (ENTRY_W+1)'(step_w);
  assign run_inc_w = run_r + ENTRY_W'(1);
  assign fsum_w    = (ENTRY_W+1)'(free_r) + (ENTRY_W+1)'(rd_data_r);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    last_nxt       = last_r;
    need_nxt       = need_r;
    run_nxt        = run_r;
    left_nxt       = left_r;
    free_nxt       = free_r;
    is_free_nxt    = is_free_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_ofs_nxt    = out_ofs_r;
    out_cnt_nxt    = out_cnt_r;
    mem_raddr      = idx_r;
    mem_waddr      = ptr_r;
    mem_wdata      = '0;
    mem_we         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + IDX_W'(1);
        if (ptr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          out_ofs_nxt = '0;
          out_cnt_nxt = '0;
          case (in_func)
            FN_ALLOC: begin
              if (need_w == '0 || need_w > (BYTES_W+1)'(TABLE_ENTRIES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOFIT;
              end else begin
                need_nxt  = need_w[ENTRY_W-1:0];
                idx_nxt   = '0;
                run_nxt   = '0;
                mem_raddr = '0;
                state_nxt = S_SCAN;
              end
            end
            FN_FREE, FN_SIZE: begin
              if (blk_w >= BYTES_W'(TABLE_ENTRIES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else begin
                idx_nxt     = blk_w[IDX_W-1:0];
                mem_raddr   = blk_w[IDX_W-1:0];
                is_free_nxt = (in_func == FN_FREE);
                state_nxt   = S_LOOKUP;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_cnt_nxt    = fbytes_w[COUNT_W-1:0];
            end
          endcase
        end
      end

      // rd_data_r holds the entry at idx_r; next read address follows the skip
      S_SCAN: begin
        if (rd_data_r == '0 && run_inc_w == need_r) begin
          start_nxt = idx_r - IDX_W'(need_r - ENTRY_W'(1));
          ptr_nxt   = idx_r - IDX_W'(need_r - ENTRY_W'(1));
          last_nxt  = idx_r;
          state_nxt = S_FILL;
        end else begin
          run_nxt = (rd_data_r == '0) ? run_inc_w : '0;
          if (sum_w >= (ENTRY_W+1)'(TABLE_ENTRIES)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOFIT;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = sum_w[IDX_W-1:0];
            mem_raddr = sum_w[IDX_W-1:0];
          end
        end
      end

      // head entry gets the run length, the rest get one
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_r == start_r) ? need_r : ENTRY_W'(1);
        ptr_nxt   = ptr_r + IDX_W'(1);
        if (ptr_r == last_r) begin
          free_nxt       = (free_r >= need_r) ? free_r - need_r : '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_ofs_nxt    = aofs_w[OFS_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      S_LOOKUP: begin
        if (is_free_r) begin
          free_nxt = (fsum_w > (ENTRY_W+1)'(TABLE_ENTRIES)) ?
                     ENTRY_W'(TABLE_ENTRIES) : fsum_w[ENTRY_W-1:0];
          if (rd_data_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end else begin
            ptr_nxt   = idx_r;
            left_nxt  = rd_data_r;
            state_nxt = S_WIPE;
          end
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_cnt_nxt    = size_w[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      // clearing stops at the last table entry
      S_WIPE: begin
        mem_we   = 1'b1;
        ptr_nxt  = ptr_r + IDX_W'(1);
        left_nxt = left_r - ENTRY_W'(1);
        if (left_r == ENTRY_W'(1) || ptr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      free_r      <= ENTRY_W'(TABLE_ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    last_r       <= last_nxt;
    need_r       <= need_nxt;
    run_r        <= run_nxt;
    left_r       <= left_nxt;
    is_free_r    <= is_free_nxt;
    out_status_r <= out_status_nxt;
    out_ofs_r    <= out_ofs_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_ofs_r;
  assign out_byte_count   = out_cnt_r;

endmodule

`default_nettype wire

@@ verif/block_table_allocator_tb.sv @@
// testbench: block table allocator checked request by request against a shadow block table
`timescale 1ns / 1ps

module block_table_allocator_tb;
  import bta_pkg::*;

  typedef struct {
    func_t              func;
    logic [BYTES_W-1:0] req;
    logic [BYTES_W-1:0] ofs;
    bit                 from_live;
  } request_t;

  typedef struct {
    status_t            status;
    logic [OFS_W-1:0]   ofs;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  func_t              in_func = FN_FBYTES;
  logic [BYTES_W-1:0] in_request_bytes = '0;
  logic [BYTES_W-1:0] in_byte_offset = '0;
  wire                busy;
  wire                out_valid;
  wire [STATUS_W-1:0] out_status;
  wire [OFS_W-1:0]    out_alloc_offset;
  wire [COUNT_W-1:0]  out_byte_count;

  block_table_allocator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_request_bytes(in_request_bytes), .in_byte_offset(in_byte_offset),
    .out_valid(out_valid), .out_status(out_status),
    .out_alloc_offset(out_alloc_offset), .out_byte_count(out_byte_count)
  );

  always #4 clk = ~clk;

  // shadow of the block table and free count
  logic [ENTRY_W-1:0] run_len [TABLE_ENTRIES];
  int                 free_cnt;
  int                 run_starts[$];

  request_t requests_todo[$];
  outcome_t outcomes_due[$];
  request_t cur;
  int       burst_left = 0;
  int       gap_left = 0;
  int       pick;
  int       errors = 0;
  int       n_total = 0;
  int       n_checked = 0;
  int       n_func[4];
  int       n_status[4];

  function automatic outcome_t apply_request(request_t rq);
    outcome_t o;
    int need, idx, run, first, blk, len;
    o = '{status: ST_OK, ofs: '0, count: '0};
    case (rq.func)
      FN_ALLOC: begin
        need = (int'(rq.req) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        o.status = ST_NOFIT;
        if (need != 0 && need <= TABLE_ENTRIES) begin
          idx = 0;
          run = 0;
          // first fit, hopping over used runs by their stored length
          while (idx < TABLE_ENTRIES && run < need) begin
            if (run_len[idx] == '0) begin
              run++;
              if (run < need) idx++;
            end else begin
              run = 0;
              idx += int'(run_len[idx]);
            end
          end
          if (run == need) begin
            first = idx - need + 1;
            run_len[first] = ENTRY_W'(need);
            for (int k = first + 1; k <= idx; k++) run_len[k] = ENTRY_W'(1);
            free_cnt = (free_cnt >= need) ? free_cnt - need : 0;
            o.status = ST_OK;
            o.ofs = OFS_W'(first * BLOCK_BYTES);
            run_starts.push_back(first);
          end
        end
      end
      FN_FREE: begin
        blk = rq.ofs / BLOCK_BYTES;
        if (blk >= TABLE_ENTRIES) begin
          o.status = ST_RANGE;
        end else begin
          len = int'(run_len[blk]);
          free_cnt = (free_cnt + len > TABLE_ENTRIES) ? TABLE_ENTRIES : free_cnt + len;
          for (int k = 0; k < len && blk + k < TABLE_ENTRIES; k++) run_len[blk + k] = '0;
        end
      end
      FN_SIZE: begin
        blk = rq.ofs / BLOCK_BYTES;
        if (blk >= TABLE_ENTRIES) o.status = ST_RANGE;
        else o.count = COUNT_W'(run_len[blk] * BLOCK_BYTES);
      end
      default: o.count = COUNT_W'(free_cnt * BLOCK_BYTES);
    endcase
    return o;
  endfunction

  function automatic request_t make_req(func_t f, int req, int ofs, bit live);
    request_t r;
    r.func = f;
    r.req = BYTES_W'(req);
    r.ofs = BYTES_W'(ofs);
    r.from_live = live;
    return r;
  endfunction

  function automatic request_t rand_req(bit alloc_heavy);
    request_t r;
    int sel, sz;
    r = make_req(FN_FBYTES, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 1'b0);
    sel = $urandom_range(99);
    if (sel < (alloc_heavy ? 45 : 30)) begin
      r.func = FN_ALLOC;
      sz = $urandom_range(9);
      if (sz < 6) r.req = BYTES_W'($urandom_range(1, 160));
      else if (sz < 8) r.req = BYTES_W'($urandom_range(161, 2048));
      else if (sz < 9) r.req = BYTES_W'($urandom_range(2049, 12000));
    end else if (sel < 75) begin
      r.func = FN_FREE;
      r.from_live = ($urandom_range(9) < 8);
      if (!r.from_live && $urandom_range(1)) begin
        r.ofs = BYTES_W'($urandom_range(TABLE_ENTRIES * BLOCK_BYTES - 1));
      end
    end else if (sel < 88) begin
      r.func = FN_SIZE;
      r.from_live = ($urandom_range(1) == 1);
    end
    return r;
  endfunction

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcomes_due.push_back(apply_request(cur));
        n_func[cur.func]++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (requests_todo.size() != 0) begin
          cur = requests_todo.pop_front();
          // aim free and size-of at a run that is believed to be live
          if (cur.from_live && run_starts.size() != 0) begin
            pick = $urandom_range(run_starts.size() - 1);
            cur.ofs = BYTES_W'(run_starts[pick] * BLOCK_BYTES + $urandom_range(BLOCK_BYTES - 1));
            if (cur.func == FN_FREE) run_starts.delete(pick);
          end
          in_func <= cur.func;
          in_request_bytes <= cur.req;
          in_byte_offset <= cur.ofs;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result must match the oldest outstanding request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      n_checked++;
      if (outcomes_due.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_status);
        errors++;
      end else begin
        automatic outcome_t e = outcomes_due.pop_front();
        n_status[e.status]++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_alloc_offset !== e.ofs) begin
          $error("alloc_offset: expected %0d, got %0d", e.ofs, out_alloc_offset);
          errors++;
        end
        if (out_byte_count !== e.count) begin
          $error("byte_count: expected %0d, got %0d", e.count, out_byte_count);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) run_len[k] = '0;
    free_cnt = TABLE_ENTRIES;
    foreach (n_func[k]) n_func[k] = 0;
    foreach (n_status[k]) n_status[k] = 0;

    // directed: edges of sizes and offsets, inner blocks, saturation, full pool
    requests_todo.push_back(make_req(FN_FBYTES, 0, 0, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 0, 16'hFFFF, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 16'hFFFF, 0, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 1, 0, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 32, 0, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 33, 0, 0));
    requests_todo.push_back(make_req(FN_SIZE, 16'hFFFF, 0, 0));
    requests_todo.push_back(make_req(FN_SIZE, 0, 3 * 32 + 31, 0));
    requests_todo.push_back(make_req(FN_SIZE, 0, 320, 0));
    requests_todo.push_back(make_req(FN_SIZE, 0, 32768, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 16'hFFFF, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 3 * 32, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 320, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 64, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 0, 0));
    requests_todo.push_back(make_req(FN_FREE, 16'hFFFF, 32, 0));
    requests_todo.push_back(make_req(FN_FBYTES, 16'hFFFF, 16'hFFFF, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 32768, 0, 0));
    requests_todo.push_back(make_req(FN_FBYTES, 0, 0, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 1, 0, 0));
    requests_todo.push_back(make_req(FN_SIZE, 0, 31, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 32767, 0));
    requests_todo.push_back(make_req(FN_ALLOC, 20, 0, 0));
    requests_todo.push_back(make_req(FN_FREE, 0, 0, 0));
    requests_todo.push_back(make_req(FN_FBYTES, 0, 0, 0));
    for (int k = 0; k < 555; k++) requests_todo.push_back(rand_req(k < 280));
    n_total = requests_todo.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every request gives exactly one strobed result
    while (n_checked < n_total) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("requests: %0d alloc, %0d free, %0d size-of, %0d free-bytes",
             n_func[FN_ALLOC], n_func[FN_FREE], n_func[FN_SIZE], n_func[FN_FBYTES]);
    $display("outcomes: %0d ok, %0d no fit, %0d out of range",
             n_status[ST_OK], n_status[ST_NOFIT], n_status[ST_RANGE]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
